### design/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
package bbc_pkg;

	typedef logic [1:0] kind_t;
	typedef logic [2:0] status_t;

	localparam kind_t KIND_PAREN = 2'd0;
	localparam kind_t KIND_BRACK = 2'd1;
	localparam kind_t KIND_BRACE = 2'd2;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_MISMATCH = 3'd1;
	localparam status_t ST_UNEXP    = 3'd2;
	localparam status_t ST_UNCLOSED = 3'd3;
	localparam status_t ST_ALL_OK   = 3'd4;
	localparam status_t ST_OVERFLOW = 3'd5;
	localparam status_t ST_IGNORED  = 3'd6;

	typedef enum logic [1:0] {
		HM_NONE  = 2'd0,
		HM_SLASH = 2'd1,
		HM_STAR  = 2'd2
	} held_t;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam int OUT_LINE_W = 16;

	function automatic logic [7:0] open_char(input kind_t k);
		logic [7:0] r;
		begin
			case (k)
				KIND_PAREN: r = CH_LPAREN;
				KIND_BRACK: r = CH_LBRACK;
				KIND_BRACE: r = CH_LBRACE;
				default:    r = CH_LPAREN;
			endcase
			return r;
		end
	endfunction

	function automatic logic [7:0] close_char(input kind_t k);
		logic [7:0] r;
		begin
			case (k)
				KIND_PAREN: r = CH_RPAREN;
				KIND_BRACK: r = CH_RBRACK;
				KIND_BRACE: r = CH_RBRACE;
				default:    r = CH_RPAREN;
			endcase
			return r;
		end
	endfunction

endpackage

### design/bracket_balance_checker_top.sv
// Bracket balance checker: comment skipping, delimiter stack in memory, result register.
//
//   channel  dir  handshake              payload
//   text     in   text_valid/text_stall  char_byte, end_of_text
//   res      out  res_valid/res_stall    status, found_char, expected_char,
//                                        opener_line, current_line, is_last
//
// One byte per cycle while text_stall is low, one result per byte, result valid the cycle after accept.
// The stack top lives in registers; the entry under it is prefetched from the
// stack memory every cycle, with a write-through bypass on push.
// No clearing pass after reset: the byte after reset is accepted at once.
// text_stall rises only while a result waits and res_stall is high.
module bracket_balance_checker_top #(
	parameter int STACK_DEPTH = 64,
	parameter int LINE_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_stall,
	input  logic [7:0]            char_byte,
	input  logic                  end_of_text,
	output logic                  res_valid,
	input  logic                  res_stall,
	output bbc_pkg::status_t      status,
	output logic [7:0]            found_char,
	output logic [7:0]            expected_char,
	output logic [15:0]           opener_line,
	output logic [15:0]           current_line,
	output logic                  is_last
);
	import bbc_pkg::*;

	localparam int DW     = $clog2(STACK_DEPTH + 1);
	localparam int AW     = $clog2(STACK_DEPTH);
	localparam int EXT_W  = (LINE_BITS > OUT_LINE_W) ? LINE_BITS : OUT_LINE_W;
	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [EXT_W-1:0] OUT_MAX = EXT_W'({OUT_LINE_W{1'b1}});

	typedef struct packed {
		kind_t                kind;
		logic [LINE_BITS-1:0] line;
	} entry_t;

	function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
		logic [EXT_W-1:0] e;
		begin
			e = EXT_W'(v);
			return (e > OUT_MAX) ? 16'hFFFF : e[15:0];
		end
	endfunction

	// state
	logic                 blk_q, lcmt_q, err_q;
	held_t                held_q;
	logic [LINE_BITS-1:0] line_q;
	logic [DW-1:0]        depth_q;
	entry_t               top_q;
	entry_t               below_q;
	entry_t               mem [STACK_DEPTH];

	// result register
	logic      res_valid_q;
	status_t   status_q;
	logic [7:0] found_q, expect_q;
	logic [15:0] oline_q, cur_q;
	logic      last_q;

	logic acc;
	assign text_stall = res_valid_q & res_stall;
	assign acc        = text_valid & ~text_stall;

	// next-state logic
	logic                 n_blk, n_lcmt, n_err;
	held_t                n_held;
	logic [LINE_BITS-1:0] n_line;
	logic [DW-1:0]        n_depth;
	entry_t               n_top;
	status_t              st;
	logic [7:0]           fnd, exp_c;
	logic [15:0]          oln, cur;
	logic                 plain, is_open, is_close, push;
	kind_t                kind;

	always_comb begin
		is_open  = 1'b0;
		is_close = 1'b0;
		kind     = KIND_PAREN;
		case (char_byte)
			CH_LPAREN: begin is_open  = 1'b1; kind = KIND_PAREN; end
			CH_LBRACK: begin is_open  = 1'b1; kind = KIND_BRACK; end
			CH_LBRACE: begin is_open  = 1'b1; kind = KIND_BRACE; end
			CH_RPAREN: begin is_close = 1'b1; kind = KIND_PAREN; end
			CH_RBRACK: begin is_close = 1'b1; kind = KIND_BRACK; end
			CH_RBRACE: begin is_close = 1'b1; kind = KIND_BRACE; end
			default: ;
		endcase
	end

	always_comb begin
		cur     = sat_line(line_q);
		st      = ST_OK;
		fnd     = 8'd0;
		exp_c   = 8'd0;
		oln     = 16'd0;
		n_blk   = blk_q;
		n_lcmt  = lcmt_q;
		n_err   = err_q;
		n_held  = held_q;
		n_line  = line_q;
		n_depth = depth_q;
		n_top   = top_q;
		plain   = 1'b0;
		push    = 1'b0;

		if (acc) begin
			if (err_q) begin
				st = ST_IGNORED;
			end else begin
				if (lcmt_q) begin
					if (char_byte == CH_LF) n_lcmt = 1'b0;
				end else if (blk_q) begin
					if (held_q == HM_STAR && char_byte == CH_SLASH) begin
						n_blk  = 1'b0;
						n_held = HM_NONE;
					end else begin
						n_held = (char_byte == CH_STAR) ? HM_STAR : HM_NONE;
					end
				end else begin
					plain = 1'b1;
					if (held_q == HM_SLASH) begin
						n_held = HM_NONE;
						if (char_byte == CH_SLASH) begin
							n_lcmt = 1'b1;
							plain  = 1'b0;
						end else if (char_byte == CH_STAR) begin
							n_blk = 1'b1;
							plain = 1'b0;
						end
					end
				end

				if (plain) begin
					n_held = HM_NONE;
					if (char_byte == CH_SLASH) begin
						n_held = HM_SLASH;
					end else if (is_open) begin
						if (depth_q == DW'(STACK_DEPTH)) begin
							st    = ST_OVERFLOW;
							fnd   = char_byte;
							exp_c = close_char(kind);
							oln   = cur;
						end else begin
							push    = 1'b1;
							n_depth = depth_q + 1'b1;
							n_top   = '{kind: kind, line: line_q};
						end
					end else if (is_close) begin
						if (depth_q == '0) begin
							st    = ST_UNEXP;
							fnd   = char_byte;
							exp_c = open_char(kind);
						end else begin
							// pop: the prefetched entry becomes the top
							n_depth = depth_q - 1'b1;
							n_top   = below_q;
							if (top_q.kind != kind) begin
								st    = ST_MISMATCH;
								fnd   = char_byte;
								exp_c = close_char(top_q.kind);
								oln   = sat_line(top_q.line);
							end
						end
					end
				end

				if (char_byte == CH_LF && line_q != LINE_MAX) n_line = line_q + 1'b1;
				if (st != ST_OK) n_err = 1'b1;

				if (end_of_text && st == ST_OK) begin
					if (n_depth != '0) begin
						st    = ST_UNCLOSED;
						fnd   = open_char(n_top.kind);
						exp_c = close_char(n_top.kind);
						oln   = sat_line(n_top.line);
					end else begin
						st = ST_ALL_OK;
					end
				end
			end

			if (end_of_text) begin
				n_blk   = 1'b0;
				n_lcmt  = 1'b0;
				n_err   = 1'b0;
				n_held  = HM_NONE;
				n_line  = LINE_BITS'(1);
				n_depth = '0;
			end
		end
	end

	// stack memory: old top spills on push; prefetch the entry under the next top
	logic          mem_we;
	logic [AW-1:0] waddr, raddr;
	assign mem_we = push & (depth_q != '0);
	assign waddr  = AW'(depth_q - 1'b1);
	assign raddr  = AW'(n_depth - DW'(2));

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= top_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we && waddr == raddr) below_q <= top_q;
		else                          below_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		top_q <= n_top;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q   <= 1'b0;
			lcmt_q  <= 1'b0;
			err_q   <= 1'b0;
			held_q  <= HM_NONE;
			line_q  <= LINE_BITS'(1);
			depth_q <= '0;
		end else begin
			blk_q   <= n_blk;
			lcmt_q  <= n_lcmt;
			err_q   <= n_err;
			held_q  <= n_held;
			line_q  <= n_line;
			depth_q <= n_depth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// load a result beat whenever a byte is taken
	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= st;
			found_q  <= fnd;
			expect_q <= exp_c;
			oline_q  <= oln;
			cur_q    <= cur;
			last_q   <= end_of_text;
		end
	end

	assign res_valid     = res_valid_q;
	assign status        = status_q;
	assign found_char    = found_q;
	assign expected_char = expect_q;
	assign opener_line   = oline_q;
	assign current_line  = cur_q;
	assign is_last       = last_q;

endmodule
